// ----- rtl/dbd_pkg.sv -----
// types and constants shared by the driving behavior decision block
package dbd_pkg;

   // decision states
   typedef enum logic [2:0] {
      ST_CRUISE    = 3'd0,
      ST_STOPLINE  = 3'd1,
      ST_INTERSECT = 3'd2,
      ST_YIELD     = 3'd3,
      ST_EMERG     = 3'd4
   } behavior_state_type;

   // request commands
   typedef enum logic {
      CMD_OBSTACLE = 1'b0,
      CMD_DECIDE   = 1'b1
   } command_type;

   // traffic light codes
   localparam logic [1:0] LIGHT_GREEN  = 2'd0;
   localparam logic [1:0] LIGHT_YELLOW = 2'd1;
   localparam logic [1:0] LIGHT_RED    = 2'd2;

   // thresholds, 1/256 m and 1/256 m/s
   localparam logic signed [24:0] CORRIDOR_MAX  = 25'sd5120;
   localparam logic signed [23:0] LATERAL_MAX   = 24'sd332;
   localparam logic signed [16:0] MIN_REL_SPEED = 17'sd26;
   localparam logic [12:0]        EMERG_DIST    = 13'd1024;
   localparam logic [12:0]        YIELD_DIST    = 13'd2560;
   localparam logic [12:0]        CLOSE_DIST    = 13'd1536;
   localparam logic [15:0]        SLOWDOWN      = 16'd512;
   localparam logic signed [23:0] STOP_LINE_MAX = 24'sd3840;

   // accelerations, 1/256 m/s^2
   localparam logic signed [11:0] ACC_DEFAULT = 12'sd256;
   localparam logic signed [11:0] ACC_EMERG   = -12'sd1280;
   localparam logic signed [11:0] ACC_YIELD   = -12'sd384;
   localparam logic signed [11:0] ACC_STOP    = -12'sd512;

   // stop distance meaning no stop
   localparam logic signed [23:0] NO_STOP = -24'sd256;

   // request transaction
   typedef struct packed {
      command_type        command;
      logic signed [23:0] ego_x;
      logic signed [23:0] obstacle_x;
      logic signed [23:0] obstacle_y;
      logic [15:0]        obstacle_speed;
      logic [15:0]        own_speed;
      logic [15:0]        speed_limit;
      logic               line_present;
      logic signed [23:0] line_distance;
      logic               in_intersection;
      logic [1:0]         light;
   } req_payload_type;

   // response transaction
   typedef struct packed {
      logic               planned;
      behavior_state_type decided_state;
      logic [15:0]        set_speed;
      logic signed [11:0] target_accel;
      logic signed [23:0] halt_distance;
      logic               emergency_brake;
   } rsp_payload_type;

endpackage

// ----- rtl/driving_behavior_decision_fsm_core.sv -----
// driving behavior decision core: obstacle tracker, decision fsm, response register
// a decide transaction's response is registered and shows in the cycle after acceptance
// one transaction per cycle unless a stuck response stalls requests; the tracker compare and the decision
// logic both sit between the request port and the response register
// obstacle transactions produce no response
// reset (synchronous, active high) clears the tracker, state to cruise, enable to 0
module driving_behavior_decision_fsm_core
   import dbd_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            csr_write_enable,
   input  logic            csr_write_data,
   input  logic            req_valid,
   output logic            req_stall,
   input  req_payload_type req_payload,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_payload_type rsp_payload
);

   logic               enable_ff;
   behavior_state_type state_ff, state_in;
   logic               found_ff, found_in;
   logic [12:0]        nearest_ff, nearest_in;
   logic [15:0]        tspeed_ff, tspeed_in;
   logic               rsp_valid_ff;
   rsp_payload_type    rsp_payload_ff, rsp_payload_in;

   logic               accept;
   logic signed [24:0] dx;
   logic               in_corridor;
   logic signed [16:0] diff;
   logic signed [18:0] diff3;
   logic               closing;
   logic               emerg_hit;
   logic               yield_hit;
   logic               approaching;
   logic               sig_stop;
   logic [15:0]        yield_speed;

   // hold off requests while a response is stuck
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;

   // corridor gate for obstacle reports
   assign dx = {req_payload.obstacle_x[23], req_payload.obstacle_x}
             - {req_payload.ego_x[23], req_payload.ego_x};
   assign in_corridor = (dx > 25'sd0) && (dx < CORRIDOR_MAX)
                      && (req_payload.obstacle_y <= LATERAL_MAX)
                      && (req_payload.obstacle_y >= -LATERAL_MAX);

   // time to collision tests as products
   assign diff    = $signed({1'b0, req_payload.own_speed}) - $signed({1'b0, tspeed_ff});
   assign diff3   = $signed({{2{diff[16]}}, diff}) + $signed({diff[16], diff, 1'b0});
   assign closing = diff >= MIN_REL_SPEED;
   assign emerg_hit = (nearest_ff < EMERG_DIST)
                    || (closing && ($signed({4'b0, nearest_ff}) < diff));
   assign yield_hit = (nearest_ff < YIELD_DIST)
                    || (closing && ($signed({6'b0, nearest_ff}) < diff3));

   // lane conditions
   assign approaching = req_payload.line_present
                      && (req_payload.line_distance > 24'sd0)
                      && (req_payload.line_distance < STOP_LINE_MAX);
   assign sig_stop = (req_payload.light == LIGHT_YELLOW) || (req_payload.light == LIGHT_RED);

   // yield speed, slowed down when close
   always_comb begin
      if (nearest_ff < CLOSE_DIST) begin
         yield_speed = (tspeed_ff > SLOWDOWN) ? tspeed_ff - SLOWDOWN : 16'd0;
      end else begin
         yield_speed = tspeed_ff;
      end
   end

   // tracker update, next state and response
   always_comb begin
      found_in       = found_ff;
      nearest_in     = nearest_ff;
      tspeed_in      = tspeed_ff;
      state_in       = state_ff;
      rsp_payload_in = '0;
      if (req_payload.command == CMD_OBSTACLE) begin
         if (in_corridor && (!found_ff || (dx[12:0] < nearest_ff))) begin
            found_in   = 1'b1;
            nearest_in = dx[12:0];
            tspeed_in  = req_payload.obstacle_speed;
         end
      end else begin
         found_in   = 1'b0;
         nearest_in = '0;
         tspeed_in  = '0;
         if (enable_ff) begin
            rsp_payload_in.planned       = 1'b1;
            rsp_payload_in.set_speed     = req_payload.speed_limit;
            rsp_payload_in.target_accel  = ACC_DEFAULT;
            rsp_payload_in.halt_distance = NO_STOP;
            if (found_ff && emerg_hit) begin
               state_in                       = ST_EMERG;
               rsp_payload_in.set_speed       = '0;
               rsp_payload_in.target_accel    = ACC_EMERG;
               rsp_payload_in.halt_distance   = {11'b0, nearest_ff};
               rsp_payload_in.emergency_brake = 1'b1;
            end else if (found_ff && yield_hit) begin
               state_in                     = ST_YIELD;
               rsp_payload_in.set_speed     = yield_speed;
               rsp_payload_in.target_accel  = ACC_YIELD;
               rsp_payload_in.halt_distance = {11'b0, nearest_ff};
            end else begin
               unique case (state_ff)
                  ST_CRUISE: begin
                     if (approaching && sig_stop) begin
                        state_in                     = ST_STOPLINE;
                        rsp_payload_in.set_speed     = '0;
                        rsp_payload_in.halt_distance = req_payload.line_distance;
                     end else if (req_payload.in_intersection) begin
                        state_in = ST_INTERSECT;
                     end else begin
                        state_in = ST_CRUISE;
                     end
                  end
                  ST_STOPLINE: begin
                     if (!sig_stop || !approaching) begin
                        state_in = ST_INTERSECT;
                     end else begin
                        state_in                     = ST_STOPLINE;
                        rsp_payload_in.set_speed     = '0;
                        rsp_payload_in.target_accel  = ACC_STOP;
                        rsp_payload_in.halt_distance = req_payload.line_distance;
                     end
                  end
                  ST_INTERSECT: begin
                     state_in = req_payload.in_intersection ? ST_INTERSECT : ST_CRUISE;
                  end
                  default: begin
                     state_in = ST_CRUISE;
                  end
               endcase
            end
            rsp_payload_in.decided_state = state_in;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff    <= 1'b0;
         state_ff     <= ST_CRUISE;
         found_ff     <= 1'b0;
         nearest_ff   <= '0;
         tspeed_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            enable_ff <= csr_write_data;
            if (csr_write_data && !enable_ff) begin
               state_ff <= ST_CRUISE;
            end
         end else if (accept) begin
            state_ff <= state_in;
         end
         if (accept) begin
            found_ff     <= found_in;
            nearest_ff   <= nearest_in;
            tspeed_ff    <= tspeed_in;
            rsp_valid_ff <= (req_payload.command == CMD_DECIDE);
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // response payload register
   always_ff @(posedge clock) begin
      if (accept && (req_payload.command == CMD_DECIDE)) begin
         rsp_payload_ff <= rsp_payload_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

// ----- rtl/dbd_checker.sv -----
// port-level checker for the driving behavior decision core, with its bind
module dbd_checker
   import dbd_pkg::*;
(
   input logic            clock,
   input logic            reset,
   input logic            req_valid,
   input logic            req_stall,
   input req_payload_type req_payload,
   input logic            rsp_valid,
   input logic            rsp_stall,
   input rsp_payload_type rsp_payload
);

   // a stalled response holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled response changed");

   // decide transaction yields a response next cycle
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_payload.command == CMD_DECIDE |=> rsp_valid)
      else $error("decide transaction without response");

   // obstacle transaction yields no response
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_payload.command == CMD_OBSTACLE |=> !rsp_valid)
      else $error("obstacle transaction produced a response");

   // disabled response is all zero
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.planned |-> rsp_payload == '0)
      else $error("unplanned response not zero");

   // emergency brake only with emergency stop at zero speed
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.emergency_brake |->
         rsp_payload.decided_state == ST_EMERG && rsp_payload.set_speed == 16'd0
         && rsp_payload.target_accel == ACC_EMERG)
      else $error("emergency brake with wrong decision");

endmodule

bind driving_behavior_decision_fsm_core dbd_checker u_dbd_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_stall   (req_stall),
   .req_payload (req_payload),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_payload (rsp_payload)
);

// ----- tb/testbench.sv -----
// self-checking testbench for the driving behavior decision core
`timescale 1ns / 100ps

module testbench
   import dbd_pkg::*;
();

   // light code with no meaning of its own, handled as green
   localparam logic [1:0] LIGHT_UNUSED = 2'd3;
   localparam int HOLD_OFF_CYCLES = 300;

   typedef enum logic {ROW_CONFIG, ROW_REQUEST} row_kind_type;

   typedef struct {
      row_kind_type    kind;
      logic            cfg_value;
      req_payload_type req;
      bit              typed;
      rsp_payload_type rsp;
   } stim_row_type;

   // dut ports, inputs known from time zero
   logic            clock = 1'b0;
   logic            reset = 1'b1;
   logic            csr_write_enable = 1'b0;
   logic            csr_write_data = 1'b0;
   logic            req_valid = 1'b0;
   logic            req_stall;
   req_payload_type req_payload = '0;
   logic            rsp_valid;
   logic            rsp_stall = 1'b0;
   rsp_payload_type rsp_payload;

   // predictor copy of the block state and register
   bit                 planner_enable = 1'b0;
   behavior_state_type fsm_state = ST_CRUISE;
   bit                 trk_found = 1'b0;
   int                 trk_distance = 0;
   int                 trk_speed = 0;

   rsp_payload_type pending_decisions[$];
   stim_row_type    directed_rows[$];

   // run bookkeeping
   int mismatch_count = 0;
   int requests_sent = 0;
   int responses_checked = 0;
   int csr_writes = 0;
   int disabled_hits = 0;
   int state_hits[8] = '{default: 0};
   bit calm_tail = 1'b0;
   bit long_hold_req = 1'b0;

   driving_behavior_decision_fsm_core i_dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_payload      (req_payload),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_payload      (rsp_payload)
   );

   // 4 ns clock
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic rsp_payload_type decision(input bit planned, input behavior_state_type st,
                                                input logic [15:0] spd,
                                                input logic signed [11:0] acc,
                                                input logic signed [23:0] sd, input bit eb);
      rsp_payload_type d;
      d.planned         = planned;
      d.decided_state   = st;
      d.set_speed       = spd;
      d.target_accel    = acc;
      d.halt_distance   = sd;
      d.emergency_brake = eb;
      return d;
   endfunction

   // tracks obstacles and plans on decide; returns 1 when a response is due
   function automatic bit plan_decision(input req_payload_type r, output rsp_payload_type d);
      int dx, ady, gap, tspd, diff, sld;
      bit found, closing, approaching, sig_stop;
      d = '0;
      if (r.command == CMD_OBSTACLE) begin
         dx  = int'(r.obstacle_x) - int'(r.ego_x);
         ady = (r.obstacle_y < 0) ? -int'(r.obstacle_y) : int'(r.obstacle_y);
         if (dx > 0 && dx < int'(CORRIDOR_MAX) && ady <= int'(LATERAL_MAX)) begin
            // strictly nearer replaces, so the first of equals stays
            if (!trk_found || dx < trk_distance) begin
               trk_found    = 1'b1;
               trk_distance = dx;
               trk_speed    = int'(r.obstacle_speed);
            end
         end
         return 1'b0;
      end

      // decide consumes and clears the tracker
      found        = trk_found;
      gap          = trk_distance;
      tspd         = trk_speed;
      trk_found    = 1'b0;
      trk_distance = 0;
      trk_speed    = 0;
      if (!planner_enable)
         return 1'b1;

      // threat checks, time to collision as products
      if (found) begin
         diff    = int'(r.own_speed) - tspd;
         closing = diff >= int'(MIN_REL_SPEED);
         if (gap < int'(EMERG_DIST) || (closing && gap < diff)) begin
            fsm_state = ST_EMERG;
            d = decision(1'b1, ST_EMERG, 16'd0, ACC_EMERG, 24'(gap), 1'b1);
            return 1'b1;
         end
         if (gap < int'(YIELD_DIST) || (closing && gap < 3 * diff)) begin
            if (gap < int'(CLOSE_DIST))
               tspd = (tspd > int'(SLOWDOWN)) ? tspd - int'(SLOWDOWN) : 0;
            fsm_state = ST_YIELD;
            d = decision(1'b1, ST_YIELD, 16'(tspd), ACC_YIELD, 24'(gap), 1'b0);
            return 1'b1;
         end
      end

      // lane and signal state machine
      sld         = int'(r.line_distance);
      approaching = r.line_present && sld > 0 && sld < int'(STOP_LINE_MAX);
      sig_stop    = (r.light == LIGHT_YELLOW) || (r.light == LIGHT_RED);
      d = decision(1'b1, ST_CRUISE, r.speed_limit, ACC_DEFAULT, NO_STOP, 1'b0);
      case (fsm_state)
         ST_CRUISE: begin
            if (approaching && sig_stop) begin
               d.decided_state = ST_STOPLINE;
               d.set_speed     = 16'd0;
               d.halt_distance = r.line_distance;
            end else if (r.in_intersection) begin
               d.decided_state = ST_INTERSECT;
            end
         end
         ST_STOPLINE: begin
            if (!sig_stop || !approaching) begin
               d.decided_state = ST_INTERSECT;
            end else begin
               d.decided_state = ST_STOPLINE;
               d.set_speed     = 16'd0;
               d.target_accel  = ACC_STOP;
               d.halt_distance = r.line_distance;
            end
         end
         ST_INTERSECT: begin
            if (r.in_intersection)
               d.decided_state = ST_INTERSECT;
         end
         default: ;
      endcase
      fsm_state = d.decided_state;
      return 1'b1;
   endfunction

   function automatic req_payload_type obstacle_req(input int ego, input int ox, input int oy,
                                                    input int spd);
      req_payload_type p;
      p                = '0;
      p.command        = CMD_OBSTACLE;
      p.ego_x          = 24'(ego);
      p.obstacle_x     = 24'(ox);
      p.obstacle_y     = 24'(oy);
      p.obstacle_speed = 16'(spd);
      return p;
   endfunction

   function automatic req_payload_type decide_req(input int ego_spd, input int limit,
                                                  input bit line, input int sld,
                                                  input bit inter, input logic [1:0] light);
      req_payload_type p;
      p                 = '0;
      p.command         = CMD_DECIDE;
      p.own_speed       = 16'(ego_spd);
      p.speed_limit     = 16'(limit);
      p.line_present    = line;
      p.line_distance   = 24'(sld);
      p.in_intersection = inter;
      p.light           = light;
      return p;
   endfunction

   function automatic req_payload_type random_payload();
      logic [159:0] raw;
      req_payload_type p;
      raw = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom()};
      p   = raw[$bits(req_payload_type)-1:0];
      return p;
   endfunction

   function automatic req_payload_type random_obstacle();
      req_payload_type p;
      int dx;
      int dx_edges[5] = '{0, 1, 5119, 5120, -1};
      int dy_edges[5] = '{-333, -332, 0, 332, 333};
      p         = random_payload();
      p.command = CMD_OBSTACLE;
      case ($urandom_range(0, 9))
         // raw noise, nearly always outside the corridor
         0: dx = int'(p.obstacle_x) - int'(p.ego_x);
         // corridor edges
         1: begin
            dx           = dx_edges[$urandom_range(0, 4)];
            p.obstacle_y = 24'(dy_edges[$urandom_range(0, 4)]);
         end
         default: begin
            case ($urandom_range(0, 2))
               0:       dx = $urandom_range(1, 1023);
               1:       dx = $urandom_range(1024, 2559);
               default: dx = $urandom_range(2560, 5119);
            endcase
            p.obstacle_y = 24'(int'($urandom_range(0, 664)) - 332);
         end
      endcase
      p.obstacle_x = p.ego_x + 24'(dx);
      if ($urandom_range(0, 3) != 0)
         p.obstacle_speed = 16'($urandom_range(0, 4000));
      return p;
   endfunction

   function automatic req_payload_type random_decide();
      req_payload_type p;
      int sld_edges[5] = '{-1, 0, 1, 3839, 3840};
      p         = random_payload();
      p.command = CMD_DECIDE;
      if ($urandom_range(0, 2) != 0)
         p.own_speed = 16'($urandom_range(0, 4000));
      if ($urandom_range(0, 3) != 0)
         p.line_present = 1'b1;
      case ($urandom_range(0, 9))
         0, 1: ;
         2:       p.line_distance = 24'(sld_edges[$urandom_range(0, 4)]);
         default: p.line_distance = 24'($urandom_range(1, 3839));
      endcase
      return p;
   endfunction

   task automatic add_row(input row_kind_type kind, input logic cfg_value,
                          input req_payload_type req, input bit typed,
                          input rsp_payload_type rsp);
      stim_row_type row;
      row.kind      = kind;
      row.cfg_value = cfg_value;
      row.req       = req;
      row.typed     = typed;
      row.rsp       = rsp;
      directed_rows.push_back(row);
   endtask

   task automatic report_mismatch(input string msg);
      mismatch_count++;
      if (mismatch_count <= 100)
         $display("mismatch at %0t ns: %s", $time, msg);
   endtask

   task automatic compare_field(input string name, input logic [31:0] got,
                                input logic [31:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
   endtask

   // offer one transaction, hold it until accepted, then maybe idle
   task automatic send_request(input req_payload_type p, input bit typed,
                               input rsp_payload_type typed_rsp);
      rsp_payload_type predicted;
      req_valid   <= 1'b1;
      req_payload <= p;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      requests_sent++;
      if (plan_decision(p, predicted))
         pending_decisions.push_back(typed ? typed_rsp : predicted);
      if (!calm_tail && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 5))
            @(posedge clock);
      end
   endtask

   // register write once the block has gone quiet
   task automatic write_enable_reg(input logic value);
      req_valid <= 1'b0;
      while (pending_decisions.size() != 0)
         @(posedge clock);
      repeat (3)
         @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      if (value && !planner_enable)
         fsm_state = ST_CRUISE;
      planner_enable = value;
      csr_writes++;
      csr_write_enable <= 1'b0;
   endtask

   // response side: random stall bursts, one long hold-off on request
   initial begin : rsp_side
      int hold_count;
      @(posedge clock);
      forever begin
         if (long_hold_req) begin
            long_hold_req = 1'b0;
            rsp_stall <= 1'b1;
            for (hold_count = 0; hold_count < HOLD_OFF_CYCLES; hold_count++)
               @(posedge clock);
         end else if (!calm_tail && $urandom_range(0, 3) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 5))
               @(posedge clock);
         end else begin
            rsp_stall <= 1'b0;
            repeat ($urandom_range(1, 8))
               @(posedge clock);
         end
      end
   end

   // compare each accepted response with the oldest predicted decision
   always @(posedge clock) begin : rsp_check
      rsp_payload_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_decisions.size() == 0) begin
            report_mismatch("response with no decision pending");
         end else begin
            want = pending_decisions.pop_front();
            compare_field("planned", rsp_payload.planned, want.planned);
            compare_field("decided_state", rsp_payload.decided_state, want.decided_state);
            compare_field("set_speed", rsp_payload.set_speed, want.set_speed);
            compare_field("target_accel", rsp_payload.target_accel, want.target_accel);
            compare_field("halt_distance", rsp_payload.halt_distance, want.halt_distance);
            compare_field("emergency_brake", rsp_payload.emergency_brake,
                          want.emergency_brake);
            responses_checked++;
            if (!want.planned)
               disabled_hits++;
            else
               state_hits[int'(want.decided_state)]++;
         end
      end
   end

   // main stimulus
   initial begin : req_side
      bit seg_enable[6];
      int seg_quota[6];
      int seg, seg_sent, n_obst;
      bit hold_done, drain_done;
      seg_enable = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1};
      seg_quota  = '{500, 150, 400, 300, 150, 350};
      hold_done  = 1'b0;
      drain_done = 1'b0;

      // directed rows: disabled, corridor edges, ties, yield, stop line, re-enable
      add_row(ROW_REQUEST, 1'b0, decide_req(65535, 65535, 1'b1, 100, 1'b1, LIGHT_RED), 1'b1,
              decision(1'b0, ST_CRUISE, 16'd0, 12'sd0, 24'sd0, 1'b0));
      add_row(ROW_REQUEST, 1'b0, obstacle_req(0, 700, -332, 65535), 1'b0, '0);
      add_row(ROW_CONFIG, 1'b1, '0, 1'b0, '0);
      add_row(ROW_REQUEST, 1'b0, decide_req(0, 0, 1'b0, 0, 1'b0, LIGHT_GREEN), 1'b1,
              decision(1'b1, ST_EMERG, 16'd0, ACC_EMERG, 24'sd700, 1'b1));
      add_row(ROW_REQUEST, 1'b0, decide_req(0, 65535, 1'b0, 0, 1'b0, LIGHT_UNUSED), 1'b1,
              decision(1'b1, ST_CRUISE, 16'hFFFF, ACC_DEFAULT, NO_STOP, 1'b0));
      add_row(ROW_REQUEST, 1'b0, obstacle_req(1000, 1000, 0, 1), 1'b0, '0);
      add_row(ROW_REQUEST, 1'b0, obstacle_req(0, 5120, 0, 1), 1'b0, '0);
      add_row(ROW_REQUEST, 1'b0, obstacle_req(0, 100, 333, 1), 1'b0, '0);
      add_row(ROW_REQUEST, 1'b0, obstacle_req(0, 100, -333, 1), 1'b0, '0);
      add_row(ROW_REQUEST, 1'b0, obstacle_req(-8388608, 8388607, 0, 1), 1'b0, '0);
      add_row(ROW_REQUEST, 1'b0, obstacle_req(8388607, -8388608, 0, 1), 1'b0, '0);
      add_row(ROW_REQUEST, 1'b0, decide_req(65535, 0, 1'b0, -8388608, 1'b0, LIGHT_RED), 1'b1,
              decision(1'b1, ST_CRUISE, 16'd0, ACC_DEFAULT, NO_STOP, 1'b0));
      add_row(ROW_REQUEST, 1'b0, obstacle_req(0, 5119, 332, 0), 1'b0, '0);
      add_row(ROW_REQUEST, 1'b0, obstacle_req(100, 5219, -332, 9), 1'b0, '0);
      add_row(ROW_REQUEST, 1'b0, decide_req(65535, 100, 1'b0, 0, 1'b0, LIGHT_GREEN), 1'b1,
              decision(1'b1, ST_EMERG, 16'd0, ACC_EMERG, 24'sd5119, 1'b1));
      add_row(ROW_REQUEST, 1'b0, obstacle_req(0, 2000, 0, 1000), 1'b0, '0);
      add_row(ROW_REQUEST, 1'b0, decide_req(0, 500, 1'b0, 0, 1'b0, LIGHT_GREEN), 1'b0, '0);
      add_row(ROW_REQUEST, 1'b0, obstacle_req(0, 1200, 0, 300), 1'b0, '0);
      add_row(ROW_REQUEST, 1'b0, decide_req(0, 500, 1'b0, 0, 1'b0, LIGHT_GREEN), 1'b0, '0);
      add_row(ROW_REQUEST, 1'b0, decide_req(0, 777, 1'b0, 0, 1'b0, LIGHT_GREEN), 1'b0, '0);
      add_row(ROW_REQUEST, 1'b0, decide_req(0, 777, 1'b1, 1000, 1'b0, LIGHT_RED), 1'b1,
              decision(1'b1, ST_STOPLINE, 16'd0, ACC_DEFAULT, 24'sd1000, 1'b0));
      add_row(ROW_REQUEST, 1'b0, decide_req(0, 777, 1'b1, 3839, 1'b0, LIGHT_YELLOW), 1'b1,
              decision(1'b1, ST_STOPLINE, 16'd0, ACC_STOP, 24'sd3839, 1'b0));
      add_row(ROW_CONFIG, 1'b0, '0, 1'b0, '0);
      add_row(ROW_REQUEST, 1'b0, decide_req(65535, 65535, 1'b1, 500, 1'b1, LIGHT_RED), 1'b1,
              decision(1'b0, ST_CRUISE, 16'd0, 12'sd0, 24'sd0, 1'b0));
      add_row(ROW_CONFIG, 1'b1, '0, 1'b0, '0);
      add_row(ROW_REQUEST, 1'b0, decide_req(0, 300, 1'b1, 1, 1'b0, LIGHT_RED), 1'b1,
              decision(1'b1, ST_STOPLINE, 16'd0, ACC_DEFAULT, 24'sd1, 1'b0));
      add_row(ROW_REQUEST, 1'b0, decide_req(0, 300, 1'b1, 3840, 1'b1, LIGHT_RED), 1'b0, '0);

      // reset
      repeat (8)
         @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == ROW_CONFIG)
            write_enable_reg(directed_rows[i].cfg_value);
         else
            send_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].rsp);
      end

      // random scenes: a few obstacles then a decide, per enable setting
      for (seg = 0; seg < 6; seg++) begin
         write_enable_reg(seg_enable[seg]);
         seg_sent = 0;
         while (seg_sent < seg_quota[seg]) begin
            n_obst = $urandom_range(0, 4);
            repeat (n_obst) begin
               send_request(random_obstacle(), 1'b0, '0);
               seg_sent++;
            end
            send_request(random_decide(), 1'b0, '0);
            seg_sent++;
            // sender waits for every decision to come back
            if (seg == 1 && !drain_done && seg_sent > 60) begin
               drain_done = 1'b1;
               req_valid <= 1'b0;
               @(posedge clock);
               while (pending_decisions.size() != 0)
                  @(posedge clock);
            end
            // long receiver hold-off while the sender keeps offering
            if (seg == 2 && !hold_done && seg_sent > 100) begin
               hold_done     = 1'b1;
               long_hold_req = 1'b1;
            end
            if (seg == 5 && seg_sent > seg_quota[5] / 3)
               calm_tail = 1'b1;
         end
      end

      // drain and finish
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_decisions.size() != 0)
         @(posedge clock);
      repeat (5)
         @(posedge clock);
      $display("ran %0d transactions, checked %0d decisions (%0d disabled) over %0d csr writes",
               requests_sent, responses_checked, disabled_hits, csr_writes);
      $display("decisions: cruise %0d, stop line %0d, intersection %0d, yield %0d, emergency %0d",
               state_hits[0], state_hits[1], state_hits[2], state_hits[3], state_hits[4]);
      if (mismatch_count == 0)
         $display("driving_behavior_decision_fsm_core test passed");
      else
         $display("driving_behavior_decision_fsm_core test failed");
      $finish;
   end

   // watchdog
   initial begin : watchdog
      #2_000_000;
      $display("timeout with %0d decisions outstanding", pending_decisions.size());
      $display("driving_behavior_decision_fsm_core test failed");
      $finish;
   end

endmodule
